// File: rtl/core/bpb_pkg.sv
// shared types, codes and helper functions for the palette blit engine
`timescale 1ns / 1ps

package bpb_pkg;

    localparam int DIM_W         = 12;
    localparam int PADDED_W      = DIM_W + 1;
    localparam int FB_ADDR_W     = 17;
    localparam int COLOR_W       = 16;
    localparam int BYTE_W        = 8;
    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_ADDR_W    = $clog2(PALETTE_DEPTH);
    localparam int CFG_INDEX_W   = 1;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd240;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd320;

    typedef enum logic [1:0] {
        CMD_START   = 2'd0,
        CMD_PALETTE = 2'd1,
        CMD_PIXEL   = 2'd2
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_index_t;

    typedef struct packed {
        cmd_t              command;
        logic [BYTE_W-1:0] palette_slot;
        logic [BYTE_W-1:0] red_byte;
        logic [BYTE_W-1:0] green_byte;
        logic [BYTE_W-1:0] blue_byte;
        logic [BYTE_W-1:0] pixel_index;
    } in_t;

    typedef struct packed {
        logic [FB_ADDR_W-1:0] fb_address;
        logic [COLOR_W-1:0]   pixel_color;
        logic                 last;
    } out_t;

    function automatic logic [DIM_W-1:0] visible_size(
        input logic [DIM_W-1:0] size,
        input logic [DIM_W-1:0] panel
    );
        return (size < panel) ? size : panel;
    endfunction

    function automatic logic [DIM_W-1:0] place_offset(
        input logic [DIM_W-1:0] size,
        input logic [DIM_W-1:0] panel
    );
        logic [DIM_W-1:0] diff;
        diff = panel - size;
        return (size < panel) ? (diff >> 1) : '0;
    endfunction

    // bmp rows are padded to a multiple of four bytes
    function automatic logic [PADDED_W-1:0] row_stride(input logic [DIM_W-1:0] size);
        return ({1'b0, size} + PADDED_W'(3)) & ~PADDED_W'(3);
    endfunction

    function automatic logic [COLOR_W-1:0] to_rgb565(
        input logic [BYTE_W-1:0] r,
        input logic [BYTE_W-1:0] g,
        input logic [BYTE_W-1:0] b
    );
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage

// File: rtl/core/bpb_palette.sv
// 256-entry rgb565 palette memory with registered read
`timescale 1ns / 1ps

module bpb_palette (
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [bpb_pkg::PAL_ADDR_W-1:0] wr_addr,
    input  logic [bpb_pkg::COLOR_W-1:0]    wr_data,
    input  logic                           rd_en,
    input  logic [bpb_pkg::PAL_ADDR_W-1:0] rd_addr,
    output logic [bpb_pkg::COLOR_W-1:0]    rd_data
);

    logic [bpb_pkg::COLOR_W-1:0] mem [bpb_pkg::PALETTE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/core/bmp_palette_blit_engine.sv
// top level of the 8 bpp bmp to rgb565 frame buffer blit engine
`timescale 1ns / 1ps

// usage
// src channel (src_valid/src_ready/src_data) carries commands: start image, palette
// entry write (blue, green, red bytes stored as rgb565) or one bmp pixel index byte.
// dst channel (dst_valid/dst_ready/dst_data) gives frame buffer address, colour and a
// last flag for each visible pixel; padding, clipped and trailing bytes give nothing.
// cfg_we/cfg_index/cfg_data write image_width (index 0) and image_height (index 1);
// placement values are worked out as the register is written, so write them idle.
// one item is taken every cycle while a result slot is free; a result passes the palette
// read stage, then the output register, before it is valid on dst.
// two result slots sit between the sides, so one more item is taken while a
// result waits; src_ready drops only when both slots are full and dst stalls.
// a palette write followed at once by a pixel reading that entry sees the new colour.
// reset clears the counters and both slots and sets width 240, height 320;
// palette contents are undefined until written.
module bmp_palette_blit_engine #(
    parameter int PANEL_WIDTH  = 240,
    parameter int PANEL_HEIGHT = 320
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            src_valid,
    output logic                            src_ready,
    input  bpb_pkg::in_t                    src_data,
    output logic                            dst_valid,
    input  logic                            dst_ready,
    output bpb_pkg::out_t                   dst_data,
    input  logic                            cfg_we,
    input  logic [bpb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bpb_pkg::DIM_W-1:0]       cfg_data
);

    localparam int DW = bpb_pkg::DIM_W;
    localparam int PW = bpb_pkg::PADDED_W;
    localparam int MW = 2 * DW;
    localparam logic [DW-1:0] PANEL_W = DW'(PANEL_WIDTH);
    localparam logic [DW-1:0] PANEL_H = DW'(PANEL_HEIGHT);

    // placement registers, loaded on configuration writes
    logic [DW-1:0] vis_w_reg;
    logic [DW-1:0] x0_reg;
    logic [PW-1:0] padded_reg;
    logic [DW-1:0] vis_h_reg;
    logic [DW-1:0] row_top_reg;

    logic [DW-1:0] byte_column_reg, byte_column_next;
    logic [DW-1:0] row_count_reg, row_count_next;

    logic                          s1_valid_reg, s1_valid_next;
    logic [bpb_pkg::FB_ADDR_W-1:0] s1_addr_reg;
    logic                          s1_last_reg;
    logic [bpb_pkg::COLOR_W-1:0]   pal_rdata;

    logic          out_valid_reg, out_valid_next;
    bpb_pkg::out_t out_data_reg;

    logic          src_fire;
    logic          s1_move;
    logic          is_pixel;
    logic          in_image;
    logic          visible;
    logic          final_px;
    logic          emit;
    logic [PW-1:0] col_inc;
    logic          row_end;
    logic [DW-1:0] row_dist;
    logic [MW-1:0] addr_full;

    logic [DW-1:0] cfg_vis_h;

    assign cfg_vis_h = bpb_pkg::visible_size(cfg_data, PANEL_H);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vis_w_reg   <= bpb_pkg::visible_size(bpb_pkg::WIDTH_RESET, PANEL_W);
            x0_reg      <= bpb_pkg::place_offset(bpb_pkg::WIDTH_RESET, PANEL_W);
            padded_reg  <= bpb_pkg::row_stride(bpb_pkg::WIDTH_RESET);
            vis_h_reg   <= bpb_pkg::visible_size(bpb_pkg::HEIGHT_RESET, PANEL_H);
            row_top_reg <= bpb_pkg::place_offset(bpb_pkg::HEIGHT_RESET, PANEL_H)
                           + bpb_pkg::visible_size(bpb_pkg::HEIGHT_RESET, PANEL_H)
                           - DW'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bpb_pkg::REG_IMAGE_WIDTH:
                begin
                    vis_w_reg  <= bpb_pkg::visible_size(cfg_data, PANEL_W);
                    x0_reg     <= bpb_pkg::place_offset(cfg_data, PANEL_W);
                    padded_reg <= bpb_pkg::row_stride(cfg_data);
                end
                bpb_pkg::REG_IMAGE_HEIGHT:
                begin
                    vis_h_reg   <= cfg_vis_h;
                    row_top_reg <= bpb_pkg::place_offset(cfg_data, PANEL_H)
                                   + cfg_vis_h - DW'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    // handshake: two result slots, s1 (palette read) and the output register
    assign s1_move   = s1_valid_reg && (!out_valid_reg || dst_ready);
    assign src_ready = !s1_valid_reg || !out_valid_reg || dst_ready;
    assign src_fire  = src_valid && src_ready;

    assign is_pixel  = (src_data.command == bpb_pkg::CMD_PIXEL);
    assign in_image  = (row_count_reg < vis_h_reg);
    assign visible   = (byte_column_reg < vis_w_reg);
    assign col_inc   = {1'b0, byte_column_reg} + PW'(1);
    assign row_end   = (col_inc >= padded_reg);
    assign final_px  = visible
                       && (({1'b0, row_count_reg} + PW'(1)) == {1'b0, vis_h_reg})
                       && (col_inc == {1'b0, vis_w_reg});
    assign emit      = src_fire && is_pixel && in_image && visible;

    // stored rows go bottom up on the panel
    assign row_dist  = row_top_reg - row_count_reg;
    assign addr_full = {{DW{1'b0}}, row_dist} * MW'(PANEL_WIDTH)
                       + MW'(x0_reg) + MW'(byte_column_reg);

    always_comb
    begin
        byte_column_next = byte_column_reg;
        row_count_next   = row_count_reg;
        if (src_fire)
        begin
            case (src_data.command)
                bpb_pkg::CMD_START:
                begin
                    byte_column_next = '0;
                    row_count_next   = '0;
                end
                bpb_pkg::CMD_PIXEL:
                begin
                    if (in_image)
                    begin
                        if (row_end)
                        begin
                            byte_column_next = '0;
                            row_count_next   = row_count_reg + DW'(1);
                        end
                        else
                        begin
                            byte_column_next = col_inc[DW-1:0];
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (src_fire)
        begin
            s1_valid_next = emit;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (dst_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_column_reg <= '0;
            row_count_reg   <= '0;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            byte_column_reg <= byte_column_next;
            row_count_reg   <= row_count_next;
            s1_valid_reg    <= s1_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            s1_addr_reg <= addr_full[bpb_pkg::FB_ADDR_W-1:0];
            s1_last_reg <= final_px;
        end
        if (s1_move)
        begin
            out_data_reg.fb_address  <= s1_addr_reg;
            out_data_reg.pixel_color <= pal_rdata;
            out_data_reg.last        <= s1_last_reg;
        end
    end

    bpb_palette u_palette (
        .clk     (clk),
        .wr_en   (src_fire && (src_data.command == bpb_pkg::CMD_PALETTE)),
        .wr_addr (src_data.palette_slot),
        .wr_data (bpb_pkg::to_rgb565(src_data.red_byte, src_data.green_byte,
                                     src_data.blue_byte)),
        .rd_en   (emit),
        .rd_addr (src_data.pixel_index),
        .rd_data (pal_rdata)
    );

    assign dst_valid = out_valid_reg;
    assign dst_data  = out_data_reg;

    // a waiting result in s1 is neither lost nor overwritten
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_move |=> s1_valid_reg && $stable(s1_addr_reg)
                                     && $stable(s1_last_reg))
        else $error("s1 result changed while waiting");

    // a start transfer clears the position counters
    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        src_fire && (src_data.command == bpb_pkg::CMD_START)
        |=> byte_column_reg == '0 && row_count_reg == '0)
        else $error("counters not cleared by start");

    // output slot drains when taken and nothing follows
    a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && dst_ready && !s1_valid_reg |=> !out_valid_reg)
        else $error("result repeated on dst");

    // no new pixel while both result slots are full and dst stalls
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !dst_ready |-> !src_ready)
        else $error("input taken with no free result slot");

endmodule

// File: dv/tb_bmp_palette_blit_engine.sv
// self-checking testbench for the palette blit engine: directed table, then random image streams
`timescale 1ns / 1ps

module tb_bmp_palette_blit_engine;

    import bpb_pkg::*;

    localparam int PANEL_W       = 240;
    localparam int PANEL_H       = 320;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int TOTAL_ITEMS   = 800;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 64;
    localparam int STREAM_CAP    = 300;
    localparam int REPORT_CAP    = 60;

    localparam logic [1:0] CMD_IGNORED = 2'd3;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_RESULT
    } check_t;

    typedef struct {
        bit               set_dims;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        in_t              item;
        check_t           chk;
        out_t             px;
    } plan_row_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             src_valid = 1'b0;
    logic             src_ready;
    in_t              src_data  = '0;
    check_t           src_chk   = CHK_MODEL;
    out_t             src_px    = '0;
    logic             dst_valid;
    logic             dst_ready = 1'b0;
    out_t             dst_data;
    logic             cfg_we    = 1'b0;
    reg_index_t       cfg_index = REG_IMAGE_WIDTH;
    logic [DIM_W-1:0] cfg_data  = '0;

    // predictor state
    logic [COLOR_W-1:0] pal_mem [PALETTE_DEPTH];
    int unsigned        col_pos   = 0;
    int unsigned        rows_done = 0;
    int unsigned        img_w     = 240;
    int unsigned        img_h     = 320;
    out_t               pending_px[$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int fed_items      = 0;
    int src_idle_pct   = 0;
    int dst_stall_pct  = 0;
    int hold_token     = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    logic [BYTE_W-1:0] last_slot = '0;

    plan_row_t plan[$];

    bmp_palette_blit_engine #(
        .PANEL_WIDTH  (PANEL_W),
        .PANEL_HEIGHT (PANEL_H)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_data  (src_data),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_data  (dst_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // works out the placed pixel for one transfer, updating the image counters and palette model
    function automatic bit place_pixel(input in_t it, output out_t px);
        int unsigned vis_w, vis_h, x0, y0, padded, addr, colour;
        bit          seen;
        px = '0;
        case (it.command)
            CMD_START:
            begin
                col_pos   = 0;
                rows_done = 0;
                return 1'b0;
            end
            CMD_PALETTE:
            begin
                colour = ((32'(it.red_byte) << 8) & 32'hf800) |
                         ((32'(it.green_byte) << 3) & 32'h07e0) |
                         ((32'(it.blue_byte) >> 3) & 32'h001f);
                pal_mem[it.palette_slot] = colour[15:0];
                return 1'b0;
            end
            CMD_PIXEL:
            begin
                vis_w = (img_w < PANEL_W) ? img_w : PANEL_W;
                vis_h = (img_h < PANEL_H) ? img_h : PANEL_H;
                if (rows_done >= vis_h)
                    return 1'b0;
                x0     = (img_w < PANEL_W) ? (PANEL_W - img_w) / 2 : 0;
                y0     = (img_h < PANEL_H) ? (PANEL_H - img_h) / 2 : 0;
                padded = (img_w + 3) & ~32'd3;
                seen   = col_pos < vis_w;
                px.last = seen && (rows_done + 1 == vis_h) && (col_pos + 1 == vis_w);
                addr = (y0 + vis_h - 1 - rows_done) * PANEL_W + x0 + col_pos;
                if (col_pos + 1 >= padded)
                begin
                    col_pos   = 0;
                    rows_done = (rows_done + 1) & 32'hfff;
                end
                else
                begin
                    col_pos = (col_pos + 1) & 32'hfff;
                end
                if (!seen)
                    return 1'b0;
                px.fb_address  = addr[FB_ADDR_W-1:0];
                px.pixel_color = pal_mem[it.pixel_index];
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    always @(posedge clk)
    begin : scoreboard
        out_t px;
        out_t want;
        bit   got;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_IMAGE_WIDTH)
                    img_w = 32'(cfg_data);
                else
                    img_h = 32'(cfg_data);
            end
            if (src_valid && src_ready)
            begin
                got = place_pixel(src_data, px);
                case (src_chk)
                    CHK_MODEL:  if (got) pending_px.push_back(px);
                    CHK_RESULT: pending_px.push_back(src_px);
                    default:    ;
                endcase
            end
            if (dst_valid && dst_ready)
            begin
                if (pending_px.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count < REPORT_CAP)
                        $display("%0t: unexpected result, expected none, %s %0d %h %b",
                                 $time, "got addr colour last", dst_data.fb_address,
                                 dst_data.pixel_color, dst_data.last);
                end
                else
                begin
                    want = pending_px.pop_front();
                    if (dst_data.fb_address !== want.fb_address)
                    begin
                        mismatch_count++;
                        if (mismatch_count < REPORT_CAP)
                            $display("%0t: fb_address expected %0d got %0d",
                                     $time, want.fb_address, dst_data.fb_address);
                    end
                    if (dst_data.pixel_color !== want.pixel_color)
                    begin
                        mismatch_count++;
                        if (mismatch_count < REPORT_CAP)
                            $display("%0t: pixel_color expected %h got %h",
                                     $time, want.pixel_color, dst_data.pixel_color);
                    end
                    if (dst_data.last !== want.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count < REPORT_CAP)
                            $display("%0t: last expected %b got %b",
                                     $time, want.last, dst_data.last);
                    end
                end
            end
        end
    end

    // receiver side: random stalls, plus a long hold-off when the driver asks for one
    always @(posedge clk)
    begin
        if (hold_seen != hold_token)
        begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            dst_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            dst_ready <= 1'b0;
        end
        else
        begin
            dst_ready <= ($urandom_range(99) >= dst_stall_pct);
        end
    end

    function automatic plan_row_t item_row(
        input cmd_t              c,
        input logic [BYTE_W-1:0] slot,
        input logic [BYTE_W-1:0] r,
        input logic [BYTE_W-1:0] g,
        input logic [BYTE_W-1:0] b,
        input logic [BYTE_W-1:0] idx,
        input check_t            chk = CHK_MODEL,
        input out_t              px = '0
    );
        plan_row_t row;
        row.set_dims          = 1'b0;
        row.w                 = '0;
        row.h                 = '0;
        row.item.command      = c;
        row.item.palette_slot = slot;
        row.item.red_byte     = r;
        row.item.green_byte   = g;
        row.item.blue_byte    = b;
        row.item.pixel_index  = idx;
        row.chk               = chk;
        row.px                = px;
        return row;
    endfunction

    function automatic plan_row_t dims_row(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        plan_row_t row;
        row          = item_row(CMD_START, '0, '0, '0, '0, '0, CHK_NONE);
        row.set_dims = 1'b1;
        row.w        = w;
        row.h        = h;
        return row;
    endfunction

    function automatic in_t rand_item(input cmd_t c);
        in_t it;
        it.command      = c;
        it.palette_slot = BYTE_W'($urandom);
        it.red_byte     = BYTE_W'($urandom);
        it.green_byte   = BYTE_W'($urandom);
        it.blue_byte    = BYTE_W'($urandom);
        it.pixel_index  = BYTE_W'($urandom);
        return it;
    endfunction

    task automatic send_item(input in_t it, input check_t chk = CHK_MODEL, input out_t px = '0);
        while ($urandom_range(99) < src_idle_pct)
        begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid <= 1'b1;
        src_data  <= it;
        src_chk   <= chk;
        src_px    <= px;
        do
            @(posedge clk);
        while (!src_ready);
        if (it.command == CMD_PALETTE)
            last_slot = it.palette_slot;
        if (it.command != cmd_t'(CMD_IGNORED))
            fed_items++;
    endtask

    // let every expected result drain, then give the pipeline time to go quiet
    task automatic settle();
        src_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_px.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_dims(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        cfg_we    <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_pixel();
        in_t it;
        it = rand_item(CMD_PIXEL);
        if ($urandom_range(3) == 0)
            it.pixel_index = last_slot;
        send_item(it);
    endtask

    initial
    begin : stimulus
        int               phase;
        int               sel;
        int unsigned      per_row;
        int unsigned      total;
        int unsigned      n;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        bit               keep;
        in_t              it;

        // reset dimensions 240 x 320: first stored byte lands at the bottom left
        plan.push_back(item_row(CMD_START, '0, '0, '0, '0, '0, CHK_NONE));
        plan.push_back(item_row(CMD_PALETTE, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff, CHK_NONE));
        plan.push_back(item_row(CMD_PALETTE, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, CHK_NONE));
        plan.push_back(item_row(CMD_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, CHK_RESULT,
                                out_t'{17'd76560, 16'h0000, 1'b0}));
        plan.push_back(item_row(CMD_PIXEL, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, CHK_RESULT,
                                out_t'{17'd76561, 16'hffff, 1'b0}));
        // palette write followed at once by a pixel reading that entry
        plan.push_back(item_row(CMD_PALETTE, 8'h81, 8'hf8, 8'h04, 8'h07, 8'h81, CHK_NONE));
        plan.push_back(item_row(CMD_PIXEL, 8'h81, 8'h00, 8'h00, 8'h00, 8'h81));
        plan.push_back(item_row(cmd_t'(CMD_IGNORED), 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                                CHK_NONE));
        // 1 x 1 image: centred, last set, then padding and trailing bytes give nothing
        plan.push_back(dims_row(12'd1, 12'd1));
        plan.push_back(item_row(CMD_START, '0, '0, '0, '0, '0, CHK_NONE));
        plan.push_back(item_row(CMD_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff, CHK_RESULT,
                                out_t'{17'd38279, 16'hffff, 1'b1}));
        repeat (4)
            plan.push_back(item_row(CMD_PIXEL, '0, '0, '0, '0, 8'h00, CHK_NONE));
        // largest image is clipped to the panel
        plan.push_back(dims_row(12'hfff, 12'hfff));
        plan.push_back(item_row(CMD_START, '0, '0, '0, '0, '0, CHK_NONE));
        plan.push_back(item_row(CMD_PIXEL, '0, '0, '0, '0, 8'h00, CHK_RESULT,
                                out_t'{17'd76560, 16'h0000, 1'b0}));
        plan.push_back(item_row(CMD_PIXEL, '0, '0, '0, '0, 8'h81));
        // zero width: every byte closes a row, nothing visible
        plan.push_back(dims_row(12'd0, 12'd2));
        plan.push_back(item_row(CMD_START, '0, '0, '0, '0, '0, CHK_NONE));
        repeat (3)
            plan.push_back(item_row(CMD_PIXEL, '0, '0, '0, '0, 8'hff, CHK_NONE));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].set_dims)
            begin
                settle();
                set_dims(plan[i].w, plan[i].h);
            end
            else
            begin
                send_item(plan[i].item, plan[i].chk, plan[i].px);
            end
        end

        // fill the whole palette so any index may be read from here on
        for (int s = 0; s < PALETTE_DEPTH; s++)
        begin
            it = rand_item(CMD_PALETTE);
            it.palette_slot = BYTE_W'(s);
            send_item(it);
        end

        phase = 0;
        while (fed_items < TOTAL_ITEMS || phase < 5)
        begin
            phase++;
            settle();
            case (phase % 4)
                0:       begin src_idle_pct = 0;  dst_stall_pct = 0;  end
                1:       begin src_idle_pct = 49; dst_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  dst_stall_pct = 49; end
                default: begin src_idle_pct = 37; dst_stall_pct = 37; end
            endcase

            if (phase == 3)
            begin
                // long receiver hold-off while the sender keeps streaming
                src_idle_pct = 0;
                set_dims(12'd240, 12'd320);
                send_item(rand_item(CMD_START));
                hold_token++;
                repeat (120) send_pixel();
            end
            else if (phase == 5)
            begin
                // climb to the last visible row with zero width, then widen mid-image
                set_dims(12'd0, 12'd3);
                send_item(rand_item(CMD_START));
                repeat (2) send_pixel();
                settle();
                set_dims(12'd1, 12'd3);
                repeat (6) send_pixel();
            end
            else
            begin
                sel  = $urandom_range(99);
                keep = 1'b0;
                if (sel < 55)
                begin
                    w = DIM_W'($urandom_range(1, 12));
                    h = DIM_W'($urandom_range(1, 8));
                end
                else if (sel < 65)
                begin
                    case ($urandom_range(4))
                        0:       w = 12'hfff;
                        1:       w = 12'd2048;
                        2:       w = 12'd241;
                        3:       w = 12'd240;
                        default: w = 12'd239;
                    endcase
                    h = DIM_W'($urandom_range(1, 3));
                end
                else if (sel < 75)
                begin
                    w = DIM_W'($urandom_range(1, 8));
                    case ($urandom_range(3))
                        0:       h = 12'hfff;
                        1:       h = 12'd321;
                        2:       h = 12'd320;
                        default: h = 12'd319;
                    endcase
                end
                else if (sel < 80)
                begin
                    w = $urandom_range(1) ? 12'd0 : 12'($urandom_range(1, 9));
                    h = (w == 0) ? 12'($urandom_range(1, 4)) : 12'd0;
                end
                else if (sel < 88)
                begin
                    w = DIM_W'($urandom_range(1, 4095));
                    h = DIM_W'($urandom_range(1, 4095));
                end
                else
                begin
                    keep = 1'b1;
                end
                if (!keep)
                    set_dims(w, h);

                // mostly whole images; some broken ones carry the old counters over
                if ($urandom_range(9) != 0)
                    send_item(rand_item(CMD_START));
                per_row = (img_w + 3) & ~32'd3;
                if (per_row == 0)
                    per_row = 1;
                total = per_row * ((img_h < PANEL_H) ? img_h : PANEL_H);
                if ($urandom_range(9) < 8)
                    n = total + $urandom_range(0, 3);
                else
                    n = $urandom_range(1, total + 1);
                if (n > STREAM_CAP)
                    n = STREAM_CAP;
                repeat (n)
                begin
                    sel = $urandom_range(99);
                    if (sel < 8)
                        send_item(rand_item(CMD_PALETTE));
                    else if (sel < 11)
                        send_item(rand_item(cmd_t'(CMD_IGNORED)));
                    send_pixel();
                end
            end
        end

        settle();
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
